// ===== rtl/core/wav_chunk_stream_parser_macros.svh =====
// -----------------------------------------------------------------------------
// WAV chunk stream parser assertion macros
// Concurrent assertion helpers that are left empty in synthesis builds.
// -----------------------------------------------------------------------------
`ifndef WAV_CHUNK_STREAM_PARSER_MACROS_SVH
`define WAV_CHUNK_STREAM_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// Checks that the consequent holds in the same cycle as the antecedent.
`define WCSP_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define WCSP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define WCSP_ASSERT_SAME(name, clk, rst_n, ante, cons, msg)
`define WCSP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/wcsp_pkg.sv =====
// -----------------------------------------------------------------------------
// WAV chunk stream parser package
// Phase codes, chunk tags, event and error codes, and the result type.
// -----------------------------------------------------------------------------
package wcsp_pkg;

  // Parser phases.
  localparam logic [3:0] PH_RIFF_ID   = 4'd0;
  localparam logic [3:0] PH_RIFF_SIZE = 4'd1;
  localparam logic [3:0] PH_WAVE_ID   = 4'd2;
  localparam logic [3:0] PH_CHUNK_ID  = 4'd3;
  localparam logic [3:0] PH_CHUNK_LEN = 4'd4;
  localparam logic [3:0] PH_FMT_BODY  = 4'd5;
  localparam logic [3:0] PH_DATA_BODY = 4'd6;
  localparam logic [3:0] PH_SKIP_BODY = 4'd7;
  localparam logic [3:0] PH_PAD       = 4'd8;

  // Chunk identifiers as they appear when shifted in big-endian order.
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // Byte offsets of the captured fields inside a fmt body.
  localparam logic [4:0] FMT_OFF_CHAN_LO = 5'd2;
  localparam logic [4:0] FMT_OFF_CHAN_HI = 5'd3;
  localparam logic [4:0] FMT_OFF_RATE_B0 = 5'd4;
  localparam logic [4:0] FMT_OFF_RATE_B1 = 5'd5;
  localparam logic [4:0] FMT_OFF_RATE_B2 = 5'd6;
  localparam logic [4:0] FMT_OFF_RATE_B3 = 5'd7;
  localparam logic [4:0] FMT_OFF_BITS_LO = 5'd14;
  localparam logic [4:0] FMT_OFF_BITS_HI = 5'd15;
  localparam logic [4:0] FMT_USED_BYTES  = 5'd16;

  localparam logic [1:0]  FIELD_LAST_BYTE = 2'd3;
  localparam logic [15:0] CHAN_MONO       = 16'd1;
  localparam logic [15:0] CHAN_STEREO     = 16'd2;
  localparam logic [15:0] BITS_8          = 16'd8;
  localparam logic [15:0] BITS_16         = 16'd16;

  // Event kinds.
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_AUDIO  = 2'd1;
  localparam logic [1:0] EV_FORMAT = 2'd2;
  localparam logic [1:0] EV_ERROR  = 2'd3;

  // Format codes.
  localparam logic [1:0] FMT_MONO8    = 2'd0;
  localparam logic [1:0] FMT_MONO16   = 2'd1;
  localparam logic [1:0] FMT_STEREO8  = 2'd2;
  localparam logic [1:0] FMT_STEREO16 = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_NO_RIFF     = 2'd1;
  localparam logic [1:0] ERR_NO_WAVE     = 2'd2;
  localparam logic [1:0] ERR_UNSUPPORTED = 2'd3;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  audio_byte;
    logic [1:0]  format_code;
    logic [31:0] sample_rate;
    logic [1:0]  error_code;
    logic        file_done;
  } wcsp_result_t;

endpackage

// ===== rtl/core/wav_chunk_stream_parser.sv =====
// -----------------------------------------------------------------------------
// WAV chunk stream parser
// Walks a RIFF/WAVE byte stream, reports the format and passes out audio bytes.
// -----------------------------------------------------------------------------
//   Channel | Handshake               | Payload
//   --------+-------------------------+---------------------------------------
//   input   | in_valid_i / in_ready_o | file_byte_i, end_of_file_i
//   output  | out_valid_o/out_ready_i | event_kind_o, audio_byte_o,
//           |                         | format_code_o, sample_rate_o,
//           |                         | error_code_o, file_done_o
//
// One byte is taken per cycle while the output is not stalled; an accepted byte
// passes the input register and then the result register, which presents it.
// The parser state advances when a byte moves from the input register into
// the result register, so the rate is set by that single parse stage.
// A stalled output fills the result register and then the input register,
// and only then drops in_ready_o. Reset needs no clearing pass.
`include "wav_chunk_stream_parser_macros.svh"

module wav_chunk_stream_parser
  import wcsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  file_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  event_kind_o,
  output logic [7:0]  audio_byte_o,
  output logic [1:0]  format_code_o,
  output logic [31:0] sample_rate_o,
  output logic [1:0]  error_code_o,
  output logic        file_done_o
);

  logic         in_valid_q;
  logic [7:0]   byte_q;
  logic         eof_q;
  logic         out_valid_q;
  wcsp_result_t result_q;
  wcsp_result_t result_d;
  logic         advance;

  // A byte moves on when the result register is empty or is being drained.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= file_byte_i;
      eof_q  <= end_of_file_i;
    end
  end

  wcsp_parse_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .file_byte_i   (byte_q),
    .end_of_file_i (eof_q),
    .result_o      (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = result_q.event_kind;
  assign audio_byte_o  = result_q.audio_byte;
  assign format_code_o = result_q.format_code;
  assign sample_rate_o = result_q.sample_rate;
  assign error_code_o  = result_q.error_code;
  assign file_done_o   = result_q.file_done;

  // A byte waiting in the input register is neither lost nor altered.
  `WCSP_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_q && !advance, in_valid_q && $stable(byte_q) && $stable(eof_q), "input register dropped a byte")

  // An error result always carries a nonzero error code.
  `WCSP_ASSERT_SAME(a_err_code, clk_i, rst_ni, out_valid_o && event_kind_o == EV_ERROR, error_code_o != ERR_NONE, "error event without an error code")

  // Only error results carry an error code, and only format results a rate.
  `WCSP_ASSERT_SAME(a_quiet_fields, clk_i, rst_ni, out_valid_o && event_kind_o != EV_ERROR, error_code_o == ERR_NONE && (event_kind_o == EV_FORMAT || sample_rate_o == '0), "stray field on a non-error result")

endmodule

// ===== rtl/core/wcsp_parse_core.sv =====
// -----------------------------------------------------------------------------
// WAV chunk stream parser core
// Parser state and the single-pass next-state and result logic for one byte.
// -----------------------------------------------------------------------------
module wcsp_parse_core
  import wcsp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   file_byte_i,
  input  logic         end_of_file_i,
  output wcsp_result_t result_o
);

  logic [3:0]  phase_q, phase_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] rem_q, rem_d;
  logic [4:0]  off_q, off_d;
  logic [15:0] chan_q, chan_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] rate_q, rate_d;
  logic        pad_q, pad_d;
  logic        hold_q, hold_d;

  logic        decide_now;
  logic        body_done_now;
  logic        fmt_ok;
  logic [1:0]  fmt_code;
  wcsp_result_t res;

  always_comb begin
    phase_d       = phase_q;
    cnt_d         = cnt_q;
    shift_d       = shift_q;
    rem_d         = rem_q;
    off_d         = off_q;
    chan_d        = chan_q;
    bits_d        = bits_q;
    rate_d        = rate_q;
    pad_d         = pad_q;
    hold_d        = hold_q;
    decide_now    = 1'b0;
    body_done_now = 1'b0;
    fmt_ok        = 1'b1;
    fmt_code      = FMT_MONO8;
    res           = '0;

    if (!hold_q) begin
      case (phase_q)
        PH_RIFF_ID, PH_WAVE_ID, PH_CHUNK_ID: begin
          shift_d = {shift_q[23:0], file_byte_i};
          if (cnt_q == FIELD_LAST_BYTE) begin
            cnt_d = '0;
            if (phase_q == PH_RIFF_ID) begin
              if (shift_d != TAG_RIFF) begin
                res.event_kind = EV_ERROR;
                res.error_code = ERR_NO_RIFF;
                hold_d         = 1'b1;
              end else begin
                phase_d = PH_RIFF_SIZE;
              end
            end else if (phase_q == PH_WAVE_ID) begin
              if (shift_d != TAG_WAVE) begin
                res.event_kind = EV_ERROR;
                res.error_code = ERR_NO_WAVE;
                hold_d         = 1'b1;
              end else begin
                phase_d = PH_CHUNK_ID;
              end
            end else begin
              rem_d   = '0;
              phase_d = PH_CHUNK_LEN;
            end
          end else begin
            cnt_d = cnt_q + 2'd1;
          end
        end
        PH_RIFF_SIZE: begin
          if (cnt_q == FIELD_LAST_BYTE) begin
            cnt_d   = '0;
            phase_d = PH_WAVE_ID;
          end else begin
            cnt_d = cnt_q + 2'd1;
          end
        end
        PH_CHUNK_LEN: begin
          // Size arrives little-endian, one byte lane per field byte.
          rem_d[{cnt_q, 3'b000} +: 8] = rem_q[{cnt_q, 3'b000} +: 8] | file_byte_i;
          if (cnt_q == FIELD_LAST_BYTE) begin
            cnt_d = '0;
            pad_d = rem_d[0];
            if (shift_q == TAG_FMT) begin
              chan_d = '0;
              bits_d = '0;
              rate_d = '0;
              off_d  = '0;
              if (rem_d == '0) begin
                decide_now = 1'b1;
              end else begin
                phase_d = PH_FMT_BODY;
              end
            end else if (rem_d == '0) begin
              body_done_now = 1'b1;
            end else if (shift_q == TAG_DATA) begin
              phase_d = PH_DATA_BODY;
            end else begin
              phase_d = PH_SKIP_BODY;
            end
          end else begin
            cnt_d = cnt_q + 2'd1;
          end
        end
        PH_FMT_BODY: begin
          case (off_q)
            FMT_OFF_CHAN_LO: chan_d[7:0]   = file_byte_i;
            FMT_OFF_CHAN_HI: chan_d[15:8]  = file_byte_i;
            FMT_OFF_RATE_B0: rate_d[7:0]   = file_byte_i;
            FMT_OFF_RATE_B1: rate_d[15:8]  = file_byte_i;
            FMT_OFF_RATE_B2: rate_d[23:16] = file_byte_i;
            FMT_OFF_RATE_B3: rate_d[31:24] = file_byte_i;
            FMT_OFF_BITS_LO: bits_d[7:0]   = file_byte_i;
            FMT_OFF_BITS_HI: bits_d[15:8]  = file_byte_i;
            default: ;
          endcase
          if (off_q < FMT_USED_BYTES) begin
            off_d = off_q + 5'd1;
          end
          rem_d = rem_q - 32'd1;
          if (rem_d == '0) begin
            decide_now = 1'b1;
          end
        end
        PH_DATA_BODY: begin
          res.event_kind = EV_AUDIO;
          res.audio_byte = file_byte_i;
          rem_d          = rem_q - 32'd1;
          if (rem_d == '0) begin
            body_done_now = 1'b1;
          end
        end
        PH_SKIP_BODY: begin
          rem_d = rem_q - 32'd1;
          if (rem_d == '0) begin
            body_done_now = 1'b1;
          end
        end
        PH_PAD: begin
          phase_d = PH_CHUNK_ID;
        end
        default: begin
          phase_d = PH_RIFF_ID;
        end
      endcase

      // Format lookup on the values as they stand after this byte's capture.
      if (chan_d == CHAN_MONO && bits_d == BITS_8) begin
        fmt_code = FMT_MONO8;
      end else if (chan_d == CHAN_MONO && bits_d == BITS_16) begin
        fmt_code = FMT_MONO16;
      end else if (chan_d == CHAN_STEREO && bits_d == BITS_8) begin
        fmt_code = FMT_STEREO8;
      end else if (chan_d == CHAN_STEREO && bits_d == BITS_16) begin
        fmt_code = FMT_STEREO16;
      end else begin
        fmt_ok = 1'b0;
      end

      // An unsupported format stops the walk; the body end is not taken then.
      if (decide_now) begin
        if (fmt_ok) begin
          res.event_kind  = EV_FORMAT;
          res.format_code = fmt_code;
          res.sample_rate = rate_d;
          body_done_now   = 1'b1;
        end else begin
          res.event_kind = EV_ERROR;
          res.error_code = ERR_UNSUPPORTED;
          hold_d         = 1'b1;
        end
      end

      if (body_done_now) begin
        phase_d = pad_d ? PH_PAD : PH_CHUNK_ID;
        pad_d   = 1'b0;
      end
    end

    res.file_done = end_of_file_i;

    // The end-of-file byte restarts the parser from the RIFF id.
    if (end_of_file_i) begin
      phase_d = PH_RIFF_ID;
      cnt_d   = '0;
      shift_d = '0;
      rem_d   = '0;
      off_d   = '0;
      chan_d  = '0;
      bits_d  = '0;
      rate_d  = '0;
      pad_d   = 1'b0;
      hold_d  = 1'b0;
    end
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF_ID;
      cnt_q   <= '0;
      shift_q <= '0;
      rem_q   <= '0;
      off_q   <= '0;
      chan_q  <= '0;
      bits_q  <= '0;
      rate_q  <= '0;
      pad_q   <= 1'b0;
      hold_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      rem_q   <= rem_d;
      off_q   <= off_d;
      chan_q  <= chan_d;
      bits_q  <= bits_d;
      rate_q  <= rate_d;
      pad_q   <= pad_d;
      hold_q  <= hold_d;
    end
  end

endmodule

// ===== dv/wav_chunk_stream_parser_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// WAV chunk stream parser checker
// Watches both channels of the parser, predicts the result of every accepted
// byte from its own model of the RIFF/WAVE walk and compares each delivered
// result field by field with the oldest prediction.
// -----------------------------------------------------------------------------
module wav_chunk_stream_parser_checker
  import wcsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  file_byte_i,
  input  logic        end_of_file_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  event_kind_i,
  input  logic [7:0]  audio_byte_i,
  input  logic [1:0]  format_code_i,
  input  logic [31:0] sample_rate_i,
  input  logic [1:0]  error_code_i,
  input  logic        file_done_i,
  output int unsigned mismatch_count_o,
  output int unsigned results_pending_o
);

  // Parser model state.
  logic [3:0]  phase;
  logic [1:0]  byte_idx;
  logic [31:0] id_shift;
  logic [31:0] remaining;
  logic [4:0]  fmt_off;
  logic [15:0] chans;
  logic [15:0] bits;
  logic [31:0] rate;
  logic        pad;
  logic        err_hold;

  wcsp_result_t predicted_results[$];
  wcsp_result_t want;
  int unsigned  mismatches;

  initial begin
    mismatch_count_o  = 0;
    results_pending_o = 0;
  end

  function automatic void clear_parse_state();
    phase    = PH_RIFF_ID;
    byte_idx = '0;
    id_shift = '0;
    remaining = '0;
    fmt_off  = '0;
    chans    = '0;
    bits     = '0;
    rate     = '0;
    pad      = 1'b0;
    err_hold = 1'b0;
  endfunction

  function automatic void close_chunk();
    phase = pad ? PH_PAD : PH_CHUNK_ID;
    pad   = 1'b0;
  endfunction

  function automatic wcsp_result_t judge_format(wcsp_result_t r);
    logic [1:0] code;
    if (chans == CHAN_MONO && bits == BITS_8) code = FMT_MONO8;
    else if (chans == CHAN_MONO && bits == BITS_16) code = FMT_MONO16;
    else if (chans == CHAN_STEREO && bits == BITS_8) code = FMT_STEREO8;
    else if (chans == CHAN_STEREO && bits == BITS_16) code = FMT_STEREO16;
    else begin
      r.event_kind = EV_ERROR;
      r.error_code = ERR_UNSUPPORTED;
      err_hold = 1'b1;
      return r;
    end
    r.event_kind  = EV_FORMAT;
    r.format_code = code;
    r.sample_rate = rate;
    return r;
  endfunction

  function automatic wcsp_result_t parse_wav_byte(logic [7:0] b, logic eof);
    wcsp_result_t r;
    logic         field_done;
    r = '0;
    r.file_done = eof;
    field_done = (byte_idx == FIELD_LAST_BYTE);
    if (!err_hold) begin
      case (phase)
        PH_RIFF_ID, PH_WAVE_ID, PH_CHUNK_ID: begin
          id_shift = {id_shift[23:0], b};
          byte_idx = byte_idx + 2'd1;
          if (field_done) begin
            if (phase == PH_RIFF_ID) begin
              if (id_shift != TAG_RIFF) begin
                r.event_kind = EV_ERROR;
                r.error_code = ERR_NO_RIFF;
                err_hold = 1'b1;
              end else begin
                phase = PH_RIFF_SIZE;
              end
            end else if (phase == PH_WAVE_ID) begin
              if (id_shift != TAG_WAVE) begin
                r.event_kind = EV_ERROR;
                r.error_code = ERR_NO_WAVE;
                err_hold = 1'b1;
              end else begin
                phase = PH_CHUNK_ID;
              end
            end else begin
              remaining = '0;
              phase = PH_CHUNK_LEN;
            end
          end
        end
        PH_RIFF_SIZE: begin
          byte_idx = byte_idx + 2'd1;
          if (field_done) phase = PH_WAVE_ID;
        end
        PH_CHUNK_LEN: begin
          remaining = remaining | (32'(b) << (8 * byte_idx));
          byte_idx = byte_idx + 2'd1;
          if (field_done) begin
            pad = remaining[0];
            if (id_shift == TAG_FMT) begin
              // A new fmt chunk forgets whatever an earlier one left behind.
              chans   = '0;
              bits    = '0;
              rate    = '0;
              fmt_off = '0;
              if (remaining == '0) begin
                r = judge_format(r);
                if (!err_hold) close_chunk();
              end else begin
                phase = PH_FMT_BODY;
              end
            end else if (remaining == '0) begin
              close_chunk();
            end else begin
              phase = (id_shift == TAG_DATA) ? PH_DATA_BODY : PH_SKIP_BODY;
            end
          end
        end
        PH_FMT_BODY: begin
          case (fmt_off)
            FMT_OFF_CHAN_LO: chans[7:0]   = b;
            FMT_OFF_CHAN_HI: chans[15:8]  = b;
            FMT_OFF_RATE_B0: rate[7:0]    = b;
            FMT_OFF_RATE_B1: rate[15:8]   = b;
            FMT_OFF_RATE_B2: rate[23:16]  = b;
            FMT_OFF_RATE_B3: rate[31:24]  = b;
            FMT_OFF_BITS_LO: bits[7:0]    = b;
            FMT_OFF_BITS_HI: bits[15:8]   = b;
            default: ;
          endcase
          if (fmt_off < FMT_USED_BYTES) fmt_off = fmt_off + 5'd1;
          remaining = remaining - 32'd1;
          if (remaining == '0) begin
            r = judge_format(r);
            if (!err_hold) close_chunk();
          end
        end
        PH_DATA_BODY: begin
          r.event_kind = EV_AUDIO;
          r.audio_byte = b;
          remaining = remaining - 32'd1;
          if (remaining == '0) close_chunk();
        end
        PH_SKIP_BODY: begin
          remaining = remaining - 32'd1;
          if (remaining == '0) close_chunk();
        end
        PH_PAD: phase = PH_CHUNK_ID;
        default: phase = PH_RIFF_ID;
      endcase
    end
    if (eof) clear_parse_state();
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse_state();
      predicted_results.delete();
      mismatches = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        predicted_results.push_back(parse_wav_byte(file_byte_i, end_of_file_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (predicted_results.size() == 0) begin
          $error("result transaction arrived with no prediction pending");
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          check_field("event_kind",  32'(want.event_kind),  32'(event_kind_i));
          check_field("audio_byte",  32'(want.audio_byte),  32'(audio_byte_i));
          check_field("format_code", 32'(want.format_code), 32'(format_code_i));
          check_field("sample_rate", want.sample_rate,      sample_rate_i);
          check_field("error_code",  32'(want.error_code),  32'(error_code_i));
          check_field("file_done",   32'(want.file_done),   32'(file_done_i));
        end
      end
    end
    mismatch_count_o  <= mismatches;
    results_pending_o <= predicted_results.size();
  end

endmodule

// ===== dv/tb_wav_chunk_stream_parser.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// WAV chunk stream parser testbench
// Feeds short directed byte streams and then randomly built RIFF/WAVE files,
// mostly well formed with random contents, some broken or cut short, under
// random stalls on both channels that stop near the end. A checker beside the
// parser predicts and compares every result.
// -----------------------------------------------------------------------------
module tb_wav_chunk_stream_parser;
  import wcsp_pkg::*;

  localparam int unsigned BYTE_TARGET = 2000;
  localparam int unsigned STALL_LIMIT = 2000;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [7:0]  file_byte   = 8'h00;
  logic        end_of_file = 1'b0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [1:0]  event_kind;
  logic [7:0]  audio_byte;
  logic [1:0]  format_code;
  logic [31:0] sample_rate;
  logic [1:0]  error_code;
  logic        file_done;

  int unsigned mismatch_count;
  int unsigned results_pending;
  int unsigned bytes_sent   = 0;
  int unsigned idle_cycles  = 0;
  bit          hold_off_req = 1'b0;
  bit          quiet        = 1'b0;

  logic [7:0] file_q[$];

  wav_chunk_stream_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .file_byte_i   (file_byte),
    .end_of_file_i (end_of_file),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .event_kind_o  (event_kind),
    .audio_byte_o  (audio_byte),
    .format_code_o (format_code),
    .sample_rate_o (sample_rate),
    .error_code_o  (error_code),
    .file_done_o   (file_done)
  );

  wav_chunk_stream_parser_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .file_byte_i       (file_byte),
    .end_of_file_i     (end_of_file),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .event_kind_i      (event_kind),
    .audio_byte_i      (audio_byte),
    .format_code_i     (format_code),
    .sample_rate_i     (sample_rate),
    .error_code_i      (error_code),
    .file_done_i       (file_done),
    .mismatch_count_o  (mismatch_count),
    .results_pending_o (results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Chunk ids go out in the order they are shifted in, sizes little-endian.
  function automatic void push_be32(logic [31:0] w);
    for (int i = 3; i >= 0; i--) file_q.push_back(w[8*i +: 8]);
  endfunction

  function automatic void push_le32(logic [31:0] w);
    for (int i = 0; i < 4; i++) file_q.push_back(w[8*i +: 8]);
  endfunction

  function automatic void push_random(int unsigned n);
    repeat (n) file_q.push_back(8'($urandom()));
  endfunction

  // Builds one file: usually a walkable RIFF/WAVE stream with random chunks,
  // now and then plain noise, a corrupted id, an endless chunk or a cut tail.
  task automatic build_random_wav();
    int unsigned   kind;
    int unsigned   len;
    int unsigned   body_len;
    int unsigned   keep;
    logic [31:0]   tag;
    logic [15:0]   chans;
    logic [15:0]   bits;
    logic [127:0]  fmt_body;
    bit            huge;
    bit            stop;
    stop = 1'b0;
    fmt_body = '0;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      push_random($urandom_range(1, 12));
      return;
    end
    push_be32(kind == 1 ? TAG_RIFF ^ (32'd1 << $urandom_range(0, 31)) : TAG_RIFF);
    push_le32($urandom());
    push_be32(kind == 2 ? TAG_WAVE ^ (32'd1 << $urandom_range(0, 31)) : TAG_WAVE);
    for (int c = $urandom_range(1, 5); c > 0 && !stop; c--) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          tag = TAG_FMT;
          case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = $urandom_range(1, 15);
            2:       len = $urandom_range(17, 24);
            default: len = 16;
          endcase
          chans = ($urandom_range(0, 5) == 0) ? 16'($urandom())
                                              : ($urandom_range(0, 1) ? CHAN_STEREO : CHAN_MONO);
          bits  = ($urandom_range(0, 5) == 0) ? 16'($urandom())
                                              : ($urandom_range(0, 1) ? BITS_16 : BITS_8);
          fmt_body = {bits, 16'($urandom()), 32'($urandom()), 32'($urandom()), chans,
                      16'($urandom())};
        end
        4, 5, 6, 7: begin
          tag = TAG_DATA;
          len = $urandom_range(0, 12);
        end
        default: begin
          tag = $urandom();
          len = $urandom_range(0, 6);
        end
      endcase
      // An oversized chunk runs past the end of the file.
      huge = ($urandom_range(0, 15) == 0);
      if (huge) begin
        len = $urandom() | 32'h8000_0000;
        stop = 1'b1;
      end
      body_len = huge ? $urandom_range(0, 6) : len;
      push_be32(tag);
      push_le32(len);
      for (int i = 0; i < body_len; i++) begin
        file_q.push_back((tag == TAG_FMT && i < 16) ? fmt_body[8*i +: 8] : 8'($urandom()));
      end
      if (!huge && len[0]) push_random(1);
    end
    if (!stop && $urandom_range(0, 7) == 0) begin
      keep = $urandom_range(1, file_q.size());
      while (file_q.size() > keep) void'(file_q.pop_back());
    end
  endtask

  // Sends the queued file byte by byte, marking the last byte as end of file.
  task automatic send_file();
    bit steady;
    steady = quiet || ($urandom_range(0, 2) == 0);
    for (int i = 0; i < file_q.size(); i++) begin
      if (!steady && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      in_valid    <= 1'b1;
      file_byte   <= file_q[i];
      end_of_file <= (i == file_q.size() - 1);
      @(posedge clk_i);
      while (!in_ready) @(posedge clk_i);
      bytes_sent++;
    end
    file_q.delete();
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Lone extreme bytes, a bad RIFF id and a bad WAVE id.
    file_q.push_back(8'h00);
    send_file();
    file_q.push_back(8'hFF);
    send_file();
    push_be32(TAG_RIFF ^ 32'h0000_0020);
    send_file();
    push_be32(TAG_RIFF);
    push_le32(32'hFFFF_FFFF);
    push_be32(TAG_WAVE ^ 32'h0000_0020);
    send_file();

    // The sender stops here until every result so far has come back.
    drain_results();

    while (bytes_sent < BYTE_TARGET) begin
      if (bytes_sent > 700) hold_off_req = 1'b1;
      if (bytes_sent > 1700) quiet = 1'b1;
      build_random_wav();
      send_file();
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // The receiver stalls in random bursts and once holds off long enough for
  // the parser to fill up and push back on the sender.
  initial begin
    bit hold_off_done;
    hold_off_done = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        out_ready <= 1'b0;
        repeat (120) @(posedge clk_i);
        hold_off_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
